// ----- rtl/dqavg_pkg.sv -----
package dqavg_pkg;

   localparam int DATA_W = 32;
   localparam int ACT_W  = 3;
   localparam int STAT_W = 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUSH_FRONT = 3'd0,
      ACT_PUSH_BACK  = 3'd1,
      ACT_POP_FRONT  = 3'd2,
      ACT_POP_BACK   = 3'd3,
      ACT_AVG_EVEN   = 3'd4
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_SUM,
      ST_SUM_END,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_REP_RD,
      ST_REP_WR
   } state_type;

   localparam logic [DATA_W-1:0] EMPTY_DATA = '1;

endpackage

// ----- rtl/dqavg_div.sv -----
module dqavg_div #(
   parameter int SUM_W = 37,
   parameter int CNT_W = 5
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [SUM_W-1:0]             dividend,
   input  logic        [CNT_W-1:0]             divisor,
   output logic                                done,
   output logic        [dqavg_pkg::DATA_W-1:0] quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  q_ff, q_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              run_ff, run_in;
   logic              neg_ff, neg_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    diff;
   logic              ge;

   assign trial = {rem_ff, q_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = trial >= {1'b0, div_ff};

   // restoring division on the magnitude, one quotient bit per cycle
   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (start) begin
         neg_in = dividend[SUM_W-1];
         q_in   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
         rem_in = '0;
         div_in = divisor;
         cnt_in = STEP_W'(SUM_W);
         run_in = 1'b1;
      end else if (run_ff) begin
         q_in   = {q_ff[SUM_W-2:0], ge};
         rem_in = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -q_ff[dqavg_pkg::DATA_W-1:0] : q_ff[dqavg_pkg::DATA_W-1:0];

endmodule

// ----- rtl/deque_with_even_average_replace_top.sv -----
// Bounded double-ended queue of signed 32-bit values in a ring memory.
// Input channel req_*: one beat carries an action (push front, push back,
// pop front, pop back, average-replace-even) and a value used by pushes.
// Result channel rsp_*: exactly one beat per request with data, status
// (ok, empty, full) and the fill count after the action.
// From the request beat to the result beat being offered:
//   push, unused codes, empty pop, average on empty queue: registered
//   straight from the request beat; pop: via the registered ring read
//   average-replace-even: the single memory read port is walked twice,
//   around the bit-serial divider; SW = 32 + clog2(QUEUE_DEPTH+1) is
//   the width of the sum that goes into the divider
// One request is in flight at a time; req_ready is low while an action runs.
// The result sits in an output register; a stalled receiver holds it and
// blocks the next request until the beat is taken.
// Reset empties the queue and drops any pending result; memory contents
// are not cleared and need not be, since only data from held entries is ever used.
module deque_with_even_average_replace_top #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic        [dqavg_pkg::ACT_W-1:0]          req_action,
   input  logic signed [dqavg_pkg::DATA_W-1:0]         req_value_in,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [dqavg_pkg::DATA_W-1:0]         rsp_data_out,
   output logic        [dqavg_pkg::STAT_W-1:0]         rsp_status,
   output logic        [$clog2(QUEUE_DEPTH+1)-1:0]     rsp_fill_count
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int PW = CW + 1;
   localparam int SW = dqavg_pkg::DATA_W + CW;
   localparam int DW = dqavg_pkg::DATA_W;

   dqavg_pkg::state_type state_ff, state_in;

   logic [AW-1:0]        front_ff, front_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic                 acc_en_ff, acc_en_in;
   logic [DW-1:0]        mean_ff, mean_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]        rsp_data_ff, rsp_data_in;
   logic [dqavg_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CW-1:0]        rsp_fill_ff, rsp_fill_in;
   logic                 rsp_load;

   logic [DW-1:0]        mem [QUEUE_DEPTH];
   logic [DW-1:0]        rd_data_ff;
   logic [AW-1:0]        rd_addr;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [DW-1:0]        wr_data;

   logic                 div_start;
   logic                 div_done;
   logic [DW-1:0]        div_quot;

   logic                 accept;
   logic                 full;
   logic                 empty;
   logic [AW-1:0]        front_dec;
   logic [AW-1:0]        front_inc;
   logic [AW-1:0]        ptr_inc;
   logic [AW-1:0]        back_addr;
   logic [AW-1:0]        last_addr;
   logic [PW-1:0]        back_sum;
   logic [PW-1:0]        last_sum;
   logic                 idx_last;
   logic signed [SW-1:0] rd_ext;

   function automatic logic [AW-1:0] ring_wrap(input logic [PW-1:0] s);
      logic [PW-1:0] r;
      r = (s >= PW'(QUEUE_DEPTH)) ? s - PW'(QUEUE_DEPTH) : s;
      return r[AW-1:0];
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == dqavg_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign full      = count_ff == CW'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign front_dec = (front_ff == '0) ? AW'(QUEUE_DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : front_ff + AW'(1);
   assign ptr_inc   = (ptr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : ptr_ff + AW'(1);
   assign back_sum  = PW'(front_ff) + PW'(count_ff);
   assign last_sum  = back_sum - PW'(1);
   assign back_addr = ring_wrap(back_sum);
   assign last_addr = ring_wrap(last_sum);
   assign idx_last  = idx_ff == (count_ff - CW'(1));
   assign rd_ext    = SW'(signed'(rd_data_ff));

   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      idx_in        = idx_ff;
      sum_in        = sum_ff;
      acc_en_in     = acc_en_ff;
      mean_in       = mean_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_load      = 1'b0;
      rsp_data_in   = '0;
      rsp_status_in = dqavg_pkg::STAT_OK;
      rsp_fill_in   = count_ff;
      rd_addr       = ptr_ff;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff;
      wr_data       = mean_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         dqavg_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  dqavg_pkg::ACT_PUSH_FRONT: begin
                     rsp_load = 1'b1;
                     if (full) begin
                        rsp_status_in = dqavg_pkg::STAT_FULL;
                     end else begin
                        wr_en       = 1'b1;
                        wr_addr     = front_dec;
                        wr_data     = req_value_in;
                        front_in    = front_dec;
                        count_in    = count_ff + CW'(1);
                        rsp_fill_in = count_in;
                     end
                  end
                  dqavg_pkg::ACT_PUSH_BACK: begin
                     rsp_load = 1'b1;
                     if (full) begin
                        rsp_status_in = dqavg_pkg::STAT_FULL;
                     end else begin
                        wr_en       = 1'b1;
                        wr_addr     = back_addr;
                        wr_data     = req_value_in;
                        count_in    = count_ff + CW'(1);
                        rsp_fill_in = count_in;
                     end
                  end
                  dqavg_pkg::ACT_POP_FRONT: begin
                     if (empty) begin
                        rsp_load      = 1'b1;
                        rsp_data_in   = dqavg_pkg::EMPTY_DATA;
                        rsp_status_in = dqavg_pkg::STAT_EMPTY;
                     end else begin
                        rd_addr  = front_ff;
                        front_in = front_inc;
                        count_in = count_ff - CW'(1);
                        state_in = dqavg_pkg::ST_POP;
                     end
                  end
                  dqavg_pkg::ACT_POP_BACK: begin
                     if (empty) begin
                        rsp_load      = 1'b1;
                        rsp_data_in   = dqavg_pkg::EMPTY_DATA;
                        rsp_status_in = dqavg_pkg::STAT_EMPTY;
                     end else begin
                        rd_addr  = last_addr;
                        count_in = count_ff - CW'(1);
                        state_in = dqavg_pkg::ST_POP;
                     end
                  end
                  dqavg_pkg::ACT_AVG_EVEN: begin
                     if (empty) begin
                        rsp_load = 1'b1;
                     end else begin
                        ptr_in    = front_ff;
                        idx_in    = '0;
                        sum_in    = '0;
                        acc_en_in = 1'b0;
                        state_in  = dqavg_pkg::ST_SUM;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         dqavg_pkg::ST_POP: begin
            rsp_load    = 1'b1;
            rsp_data_in = rd_data_ff;
            state_in    = dqavg_pkg::ST_IDLE;
         end
         dqavg_pkg::ST_SUM: begin
            // read data arrives in the cycle after its address
            if (acc_en_ff) begin
               sum_in = sum_ff + rd_ext;
            end
            acc_en_in = 1'b1;
            ptr_in    = ptr_inc;
            idx_in    = idx_ff + CW'(1);
            if (idx_last) begin
               state_in = dqavg_pkg::ST_SUM_END;
            end
         end
         dqavg_pkg::ST_SUM_END: begin
            sum_in    = sum_ff + rd_ext;
            acc_en_in = 1'b0;
            state_in  = dqavg_pkg::ST_DIV_GO;
         end
         dqavg_pkg::ST_DIV_GO: begin
            div_start = 1'b1;
            state_in  = dqavg_pkg::ST_DIV_WAIT;
         end
         dqavg_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               mean_in  = div_quot;
               ptr_in   = front_ff;
               idx_in   = '0;
               state_in = dqavg_pkg::ST_REP_RD;
            end
         end
         dqavg_pkg::ST_REP_RD: begin
            state_in = dqavg_pkg::ST_REP_WR;
         end
         dqavg_pkg::ST_REP_WR: begin
            if (!rd_data_ff[0]) begin
               wr_en = 1'b1;
            end
            ptr_in = ptr_inc;
            idx_in = idx_ff + CW'(1);
            if (idx_last) begin
               rsp_load    = 1'b1;
               rsp_data_in = mean_ff;
               state_in    = dqavg_pkg::ST_IDLE;
            end else begin
               state_in = dqavg_pkg::ST_REP_RD;
            end
         end
         default: begin
            state_in = dqavg_pkg::ST_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dqavg_pkg::ST_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         acc_en_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_en_ff    <= acc_en_in;
      end
      ptr_ff  <= ptr_in;
      idx_ff  <= idx_in;
      sum_ff  <= sum_in;
      mean_ff <= mean_in;
      if (rsp_load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= rsp_status_in;
         rsp_fill_ff   <= rsp_fill_in;
      end
   end

   // ring memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   dqavg_div #(
      .SUM_W (SW),
      .CNT_W (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_fill_count = rsp_fill_ff;

endmodule

// ----- rtl/dqavg_chk.sv -----
module dqavg_chk #(
   parameter int QUEUE_DEPTH = 16
) (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic [dqavg_pkg::DATA_W-1:0]            rsp_data_out,
   input logic [dqavg_pkg::STAT_W-1:0]            rsp_status,
   input logic [$clog2(QUEUE_DEPTH+1)-1:0]        rsp_fill_count
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // a stalled result beat holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out)
         && $stable(rsp_status) && $stable(rsp_fill_count))
      else $error("result beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dqavg_pkg::STAT_FULL)
         |-> rsp_fill_count == CW'(QUEUE_DEPTH))
      else $error("full status without a full queue");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == dqavg_pkg::STAT_EMPTY)
         |-> (rsp_fill_count == '0) && (rsp_data_out == dqavg_pkg::EMPTY_DATA))
      else $error("empty status with wrong data or count");

   // a waiting result beat blocks the next request
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while a result beat waits");

endmodule

bind deque_with_even_average_replace_top dqavg_chk #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dqavg_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_data_out   (rsp_data_out),
   .rsp_status     (rsp_status),
   .rsp_fill_count (rsp_fill_count)
);
